// ----- rtl/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg: shared types and constants of the descriptor slot allocator
// Item layouts, configuration layout, operation and status codes, register
// indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_RANGE_DEF = 64;

    localparam int ADDR_W     = 64;
    localparam int SIZE_W     = 13;
    localparam int CAP_W      = 11;
    localparam int COUNT_W    = 7;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 10;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFILL = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_FREE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_MISALIGNED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESC_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd4;

    localparam logic [SIZE_W-1:0] DESC_SIZE_RST = 13'd32;
    localparam logic [CAP_W-1:0]  CAPACITY_RST  = 11'd1024;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] slot_count;
        logic [ADDR_W-1:0]  handle_address;
    } cmd_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   cpu_handle;
        logic [ADDR_W-1:0]   gpu_handle;
        logic [SLOT_W-1:0]   slot_index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } rsp_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] cpu_base;
        logic [ADDR_W-1:0] gpu_base;
        logic [SIZE_W-1:0] descriptor_size;
        logic              shader_visible;
        logic [CAP_W-1:0]  capacity;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC_READ,
        S_ALLOC_MUL,
        S_ALLOC_OUT,
        S_ALLOC_ERR,
        S_FREE_DIV,
        S_FREE_OUT,
        S_REFILL
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic div_start;
        logic refill_start;
        logic refill_step;
        logic refill_finish;
        logic rd_issue;
        logic mul_en;
        logic emit_alloc;
        logic emit_err;
        logic emit_free;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              enough_free;
        logic              last_pop;
        logic              div_done;
        logic              refill_done;
        logic              out_free;
    } dp_stat_t;

endpackage

// ----- rtl/dsa_stream_if.sv -----
// ----------------------------------------------------------------------------
// dsa_stream_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface dsa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/dsa_divider.sv -----
// ----------------------------------------------------------------------------
// dsa_divider: iterative restoring divider
// Divides a 64-bit offset by a 13-bit nonzero stride, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dsa_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dsa_pkg::ADDR_W-1:0]   dividend,
    input  logic [dsa_pkg::SIZE_W-1:0]   divisor,
    output logic                         done,
    output logic [dsa_pkg::ADDR_W-1:0]   quotient,
    output logic [dsa_pkg::SIZE_W-1:0]   remainder
);
    import dsa_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0]    quo_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic [SIZE_W-1:0]    dvs_reg;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;
    logic                 fits;

    // The partial remainder stays below the divisor, so the shifted trial
    // value stays below twice the divisor and one subtract settles a bit.
    always_comb
    begin
        trial = {rem_reg, quo_reg[ADDR_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - DIV_CNT_W'(1);
            if (step_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ADDR_W-2:0], fits};
            rem_reg <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        end
    end

    assign done      = !busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/dsa_datapath.sv -----
// ----------------------------------------------------------------------------
// dsa_datapath: free ring, counters, handle arithmetic and result register
// Executes the controller's commands and reports status back to it.
// ----------------------------------------------------------------------------
module dsa_datapath #(
    parameter int DEPTH     = dsa_pkg::DEPTH_DEF,
    parameter int MAX_RANGE = dsa_pkg::MAX_RANGE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dsa_pkg::cfg_t      cfg,
    input  dsa_pkg::cmd_item_t item,
    input  dsa_pkg::ctl_cmd_t  ctl,
    output dsa_pkg::dp_stat_t  stat,
    dsa_stream_if.source       rsp
);
    import dsa_pkg::*;

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PROD_W = AW + SIZE_W;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int EF_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SUM_W  = CNT_W + 1;

    // Free ring storage; entries hold slot indexes.
    logic [AW-1:0] ring_mem [DEPTH];

    logic [KIND_W-1:0]  kind_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [AW-1:0]      rd_data_reg;
    logic [PROD_W-1:0]  prod_reg;
    rsp_item_t          out_reg, out_next;

    logic [AW-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]   free_cnt_reg, free_cnt_next;
    logic [COUNT_W-1:0] pop_cnt_reg, pop_cnt_next;
    logic [CNT_W-1:0]   fill_idx_reg, fill_idx_next;
    logic               out_valid_reg, out_valid_next;

    logic [COUNT_W-1:0]  count_eff;
    logic [SIZE_W-1:0]   stride;
    logic [CNT_W-1:0]    cap_eff;
    logic [AW-1:0]       head_inc;
    logic [SUM_W-1:0]    tail_sum;
    logic [SUM_W-1:0]    tail_wrap;
    logic [AW-1:0]       tail;
    logic                ring_full;
    logic                div_done;
    logic [ADDR_W-1:0]   div_q;
    logic [SIZE_W-1:0]   div_r;
    logic [STATUS_W-1:0] free_status;
    logic                free_ok;
    logic                emit_any;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_wdata;

    // Request size: zero means one, anything above the range limit saturates.
    always_comb
    begin
        count_eff = item.slot_count;
        if (item.slot_count == '0)
        begin
            count_eff = COUNT_W'(1);
        end
        else if (item.slot_count > COUNT_W'(MAX_RANGE))
        begin
            count_eff = COUNT_W'(MAX_RANGE);
        end
    end

    always_comb
    begin
        stride    = (cfg.descriptor_size == '0) ? SIZE_W'(1) : cfg.descriptor_size;
        cap_eff   = (CMP_W'(cfg.capacity) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                           : CNT_W'(cfg.capacity);
        head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        tail_sum  = SUM_W'(head_reg) + SUM_W'(free_cnt_reg);
        tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
        tail      = tail_wrap[AW-1:0];
        ring_full = (free_cnt_reg == CNT_W'(DEPTH));
    end

    dsa_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (addr_reg - cfg.cpu_base),
        .divisor   (stride),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Free checks in priority order: alignment, range, then ring space.
    always_comb
    begin
        if (div_r != '0)
        begin
            free_status = STAT_MISALIGNED;
        end
        else if (div_q >= ADDR_W'(cap_eff))
        begin
            free_status = STAT_RANGE;
        end
        else if (ring_full)
        begin
            free_status = STAT_FULL;
        end
        else
        begin
            free_status = STAT_OK;
        end
        free_ok = (free_status == STAT_OK);
    end

    // Single write port shared by the refill sweep and the push of a free.
    always_comb
    begin
        mem_we    = ctl.refill_step || (ctl.emit_free && free_ok);
        mem_waddr = ctl.refill_step ? fill_idx_reg[AW-1:0] : tail;
        mem_wdata = ctl.refill_step ? fill_idx_reg[AW-1:0] : div_q[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.rd_issue)
        begin
            rd_data_reg <= ring_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            kind_reg  <= item.kind;
            count_reg <= count_eff;
            addr_reg  <= item.handle_address;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= PROD_W'(rd_data_reg) * PROD_W'(stride);
        end
        if (emit_any)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        out_next = '0;
        if (ctl.emit_alloc)
        begin
            out_next.cpu_handle = cfg.cpu_base + ADDR_W'(prod_reg);
            out_next.gpu_handle = cfg.shader_visible ? cfg.gpu_base + ADDR_W'(prod_reg)
                                                     : '0;
            out_next.slot_index = SLOT_W'(rd_data_reg);
            out_next.status     = STAT_OK;
            out_next.last       = stat.last_pop;
        end
        else if (ctl.emit_free)
        begin
            out_next.cpu_handle = addr_reg;
            out_next.slot_index = free_ok ? SLOT_W'(div_q[AW-1:0]) : '0;
            out_next.status     = free_status;
            out_next.last       = 1'b1;
        end
        else
        begin
            out_next.status = STAT_NO_FREE;
            out_next.last   = 1'b1;
        end
    end

    assign emit_any = ctl.emit_alloc || ctl.emit_free || ctl.emit_err;

    always_comb
    begin
        head_next      = head_reg;
        free_cnt_next  = free_cnt_reg;
        pop_cnt_next   = pop_cnt_reg;
        fill_idx_next  = fill_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (ctl.load_item)
        begin
            pop_cnt_next = '0;
        end
        if (ctl.refill_start)
        begin
            head_next     = '0;
            free_cnt_next = '0;
            fill_idx_next = '0;
        end
        if (ctl.refill_step)
        begin
            fill_idx_next = fill_idx_reg + CNT_W'(1);
        end
        if (ctl.refill_finish)
        begin
            free_cnt_next = cap_eff;
        end
        if (ctl.emit_alloc)
        begin
            head_next     = head_inc;
            free_cnt_next = free_cnt_reg - CNT_W'(1);
            pop_cnt_next  = pop_cnt_reg + COUNT_W'(1);
        end
        if (ctl.emit_free && free_ok)
        begin
            free_cnt_next = free_cnt_reg + CNT_W'(1);
        end
        if (emit_any)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            free_cnt_reg  <= '0;
            pop_cnt_reg   <= '0;
            fill_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            free_cnt_reg  <= free_cnt_next;
            pop_cnt_reg   <= pop_cnt_next;
            fill_idx_reg  <= fill_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        stat.kind        = kind_reg;
        stat.enough_free = (EF_W'(free_cnt_reg) >= EF_W'(count_reg));
        stat.last_pop    = (pop_cnt_reg == count_reg - COUNT_W'(1));
        stat.div_done    = div_done;
        stat.refill_done = (fill_idx_reg == cap_eff);
        stat.out_free    = !out_valid_reg || rsp.ready;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

// ----- rtl/dsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsa_ctrl: allocator sequencer
// Steps each item through allocate, free or refill and issues datapath commands.
// ----------------------------------------------------------------------------
module dsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dsa_pkg::dp_stat_t stat,
    output dsa_pkg::ctl_cmd_t ctl
);
    import dsa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.kind)
                    KIND_ALLOC:
                    begin
                        state_next = stat.enough_free ? S_ALLOC_READ : S_ALLOC_ERR;
                    end
                    KIND_FREE:
                    begin
                        ctl.div_start = 1'b1;
                        state_next    = S_FREE_DIV;
                    end
                    KIND_REFILL:
                    begin
                        ctl.refill_start = 1'b1;
                        state_next       = S_REFILL;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ALLOC_READ:
            begin
                ctl.rd_issue = 1'b1;
                state_next   = S_ALLOC_MUL;
            end
            S_ALLOC_MUL:
            begin
                ctl.mul_en = 1'b1;
                state_next = S_ALLOC_OUT;
            end
            S_ALLOC_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_alloc = 1'b1;
                    state_next     = stat.last_pop ? S_IDLE : S_ALLOC_READ;
                end
            end
            S_ALLOC_ERR:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FREE_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FREE_OUT;
                end
            end
            S_FREE_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_free = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_REFILL:
            begin
                if (stat.refill_done)
                begin
                    ctl.refill_finish = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    ctl.refill_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/descriptor_slot_allocator.sv -----
// Allocate: each slot takes a ring read, a stride multiply and a handle add into the result
// register, which waits while that register is full; a request that finds too few free slots gets an error result.
// A free runs the bit-serial 64-bit offset divider, then loads its result when the result register is free.
// A refill item does one ring write a cycle and gives no result.
// One item is in flight at a time; the result register lets the next item enter while it waits.
// Reset: configuration returns to its defaults, the ring is empty; ring contents are not cleared.
// ----------------------------------------------------------------------------
// descriptor_slot_allocator: FIFO free-list allocator of descriptor slots
// Pops slot indexes from a ring for allocations, pushes them back on free.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator #(
    parameter int DEPTH     = dsa_pkg::DEPTH_DEF,
    parameter int MAX_RANGE = dsa_pkg::MAX_RANGE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dsa_stream_if.sink                      cmd,
    dsa_stream_if.source                    rsp,
    input  logic                            cfg_we,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import dsa_pkg::*;

    // The configuration registers live here and feed the datapath as one
    // bundle. Writes to indexes past the register list are dropped.
    cfg_t     cfg_reg, cfg_next;
    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CPU_BASE:  cfg_next.cpu_base        = cfg_wdata;
                CFG_GPU_BASE:  cfg_next.gpu_base        = cfg_wdata;
                CFG_DESC_SIZE: cfg_next.descriptor_size = cfg_wdata[SIZE_W-1:0];
                CFG_VISIBLE:   cfg_next.shader_visible  = cfg_wdata[0];
                CFG_CAPACITY:  cfg_next.capacity        = cfg_wdata[CAP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cpu_base        <= '0;
            cfg_reg.gpu_base        <= '0;
            cfg_reg.descriptor_size <= DESC_SIZE_RST;
            cfg_reg.shader_visible  <= 1'b0;
            cfg_reg.capacity        <= CAPACITY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The controller takes an item only from its idle state and walks it
    // through the datapath; the ring, counters and item registers sit in the datapath.
    dsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .stat     (dp_stat),
        .ctl      (ctl_cmd)
    );

    dsa_datapath #(
        .DEPTH     (DEPTH),
        .MAX_RANGE (MAX_RANGE)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (cmd.payload),
        .ctl   (ctl_cmd),
        .stat  (dp_stat),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    // After an item is taken the controller is not ready again in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("input taken again right after an accepted item");

    // Ring writes, pops and result loads never collide in one cycle.
    a_single_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl_cmd.emit_alloc, ctl_cmd.emit_free, ctl_cmd.emit_err,
                  ctl_cmd.refill_step}))
        else $error("more than one datapath action in one cycle");

    // A result is only loaded when the result register can take it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_cmd.emit_alloc || ctl_cmd.emit_free || ctl_cmd.emit_err) |-> dp_stat.out_free)
        else $error("result register overwritten before it was taken");
`endif

endmodule
